// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the SHA-256 hasher.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/sha256mh_pkg.sv =====
// Types, codes and constant tables for the SHA-256 hasher.
// No dependencies; compiled first.
package sha256mh_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUTPUT
    } ctrl_state_t;

    // Padding progress of the message being closed
    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ZERO,
        PH_LEN_LO,
        PH_DONE
    } pad_phase_t;

    // Source of the word shifted into the schedule window
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } word_src_t;

    typedef struct packed {
        logic       accept;
        logic       push;
        word_src_t  src;
        logic       load_vars;
        logic       round;
        logic [5:0] round_index;
        logic       finish;
        logic       out_load;
        logic [2:0] out_idx;
        logic       restart;
    } dp_cmd_t;

    typedef struct packed {
        logic eom;
        logic full_word;
    } dp_status_t;

    localparam logic [3:0]  LAST_SLOT       = 4'd15;
    localparam logic [3:0]  LENGTH_SLOT     = 4'd14;
    localparam logic [5:0]  LAST_ROUND      = 6'd63;
    localparam logic [2:0]  LAST_WORD_INDEX = 3'd7;
    localparam logic [2:0]  FULL_COUNT      = 3'd4;
    localparam logic [31:0] MARK_WORD       = 32'h8000_0000;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== hw/rtl/sha256mh_stream_if.sv =====
// Valid/ready channel interfaces for message words and digest words.
// Depends on sha256mh_pkg for the payload types.
interface sha256mh_msg_if;
    import sha256mh_pkg::*;
    logic      valid;
    logic      ready;
    msg_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha256mh_digest_if;
    import sha256mh_pkg::*;
    logic         valid;
    logic         ready;
    digest_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/sha256mh_ctrl.sv =====
// Sequencer: block fill count, padding steps, round counter, digest readout.
// Depends on sha256mh_pkg.
module sha256mh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_ready,
    output logic                   digest_valid,
    input  logic                   digest_ready,
    input  sha256mh_pkg::dp_status_t status,
    output sha256mh_pkg::dp_cmd_t    cmd
);
    import sha256mh_pkg::*;

    ctrl_state_t state_reg, state_next;
    pad_phase_t  phase_reg, phase_next;
    logic [3:0]  wic_reg, wic_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_NONE;
            wic_reg       <= '0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wic_reg       <= wic_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Commands to the datapath
    always_comb
    begin
        cmd             = '0;
        cmd.src         = SRC_INPUT;
        cmd.round_index = round_reg;
        cmd.out_idx     = out_idx_reg;
        msg_ready       = (state_reg == ST_IDLE);
        digest_valid    = out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = msg_valid;
                cmd.push   = msg_valid;
            end
            ST_PAD:
            begin
                cmd.push = 1'b1;
                case (phase_reg)
                    PH_MARK:   cmd.src = SRC_MARK;
                    PH_ZERO:   cmd.src = (wic_reg == LENGTH_SLOT) ? SRC_LEN_HI : SRC_ZERO;
                    PH_LEN_LO: cmd.src = SRC_LEN_LO;
                    default:   cmd.src = SRC_ZERO;
                endcase
            end
            ST_ROUND:  cmd.round  = 1'b1;
            ST_FINISH: cmd.finish = 1'b1;
            ST_OUTPUT:
            begin
                cmd.out_load = !out_valid_reg || digest_ready;
                cmd.restart  = cmd.out_load && (out_idx_reg == LAST_WORD_INDEX);
            end
            default: cmd = '0;
        endcase
        // the block-completing push also loads a..h for the rounds
        cmd.load_vars = cmd.push && (wic_reg == LAST_SLOT);
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        wic_next       = wic_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg;

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (digest_ready)
            out_valid_next = 1'b0;

        if (cmd.push)
        begin
            wic_next = wic_reg + 4'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.eom)
                begin
                    phase_next = status.full_word ? PH_MARK : PH_ZERO;
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                case (phase_reg)
                    PH_MARK:   phase_next = PH_ZERO;
                    PH_ZERO:   phase_next = (wic_reg == LENGTH_SLOT) ? PH_LEN_LO : PH_ZERO;
                    PH_LEN_LO: phase_next = PH_DONE;
                    default:   phase_next = phase_reg;
                endcase
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                case (phase_reg)
                    PH_DONE: state_next = ST_OUTPUT;
                    PH_NONE: state_next = ST_IDLE;
                    default: state_next = ST_PAD;
                endcase
            end
            ST_OUTPUT:
            begin
                if (cmd.out_load)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD_INDEX)
                    begin
                        state_next = ST_IDLE;
                        phase_next = PH_NONE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // a full block overrides the flow above: run the rounds first
        if (cmd.load_vars)
        begin
            state_next = ST_ROUND;
            round_next = '0;
        end
    end

endmodule

// ===== hw/rtl/sha256mh_datapath.sv =====
// Hash state, working variables, schedule shift line, length and output register.
// Depends on sha256mh_pkg; driven by sha256mh_ctrl.
module sha256mh_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sha256mh_pkg::dp_cmd_t      cmd,
    output sha256mh_pkg::dp_status_t   status,
    input  sha256mh_pkg::msg_item_t    msg,
    output sha256mh_pkg::digest_item_t result
);
    import sha256mh_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0]  h_reg [8];
    logic [31:0]  h_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [63:0]  len_reg, len_next;
    digest_item_t out_reg, out_next;

    logic [2:0]  count_eff;
    logic [31:0] in_word;
    logic [31:0] push_word;
    logic [31:0] new_w;
    logic [31:0] t1, t2;
    logic [31:0] ssig0, ssig1, bsig0, bsig1, ch, maj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= HASH_IV;
            len_reg <= '0;
        end
        else
        begin
            h_reg   <= h_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        w_reg   <= w_next;
        out_reg <= out_next;
    end

    assign result = out_reg;

    // Oversized counts and non-final words count as four bytes
    always_comb
    begin
        count_eff = (!msg.end_of_message || msg.byte_count > FULL_COUNT)
                    ? FULL_COUNT : msg.byte_count;
        status.eom       = msg.end_of_message;
        status.full_word = (count_eff == FULL_COUNT);
        // short final word: clear trailing bytes and merge the 0x80 mark
        case (count_eff)
            3'd0:    in_word = MARK_WORD;
            3'd1:    in_word = {msg.message_word[31:24], 24'h80_0000};
            3'd2:    in_word = {msg.message_word[31:16], 16'h8000};
            3'd3:    in_word = {msg.message_word[31:8], 8'h80};
            default: in_word = msg.message_word;
        endcase
    end

    always_comb
    begin
        case (cmd.src)
            SRC_INPUT:  push_word = in_word;
            SRC_MARK:   push_word = MARK_WORD;
            SRC_LEN_HI: push_word = len_reg[63:32];
            SRC_LEN_LO: push_word = len_reg[31:0];
            default:    push_word = '0;
        endcase
    end

    // Round logic; window holds W[t..t+15], w_reg[0] is this round's word
    always_comb
    begin
        ssig0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        ssig1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        new_w = w_reg[0] + ssig0 + w_reg[9] + ssig1;
        bsig1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        bsig0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + bsig1 + ch + ROUND_K[cmd.round_index] + w_reg[0];
        t2    = bsig0 + maj;
    end

    always_comb
    begin
        w_next = w_reg;
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15] = cmd.push ? push_word : new_w;
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (cmd.load_vars)
            v_next = h_reg;
        else if (cmd.round)
        begin
            for (int i = 1; i < 8; i++)
                v_next[i] = v_reg[i - 1];
            v_next[4] = v_reg[3] + t1;
            v_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        h_next   = h_reg;
        len_next = len_reg;
        if (cmd.finish)
        begin
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + v_reg[i];
        end
        else if (cmd.restart)
        begin
            h_next   = HASH_IV;
            len_next = '0;
        end
        if (cmd.accept)
            len_next = len_reg + {58'd0, count_eff, 3'd0};
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_next.digest_word = h_reg[cmd.out_idx];
            out_next.word_index  = cmd.out_idx;
            out_next.last_word   = (cmd.out_idx == LAST_WORD_INDEX);
        end
    end

endmodule

// ===== hw/rtl/sha256_message_hasher_core.sv =====
// SHA-256 message hasher, top level: sequencer plus datapath.
// Depends on sha256mh_pkg, the stream interfaces, sha256mh_ctrl, sha256mh_datapath
// and assert_macros.svh.
//
// Usage
//  - message: big-endian 32-bit words, first byte in bits 31..24. byte_count gives
//    the valid leading bytes of the final word (end_of_message set); it is taken as
//    four on every other word, and any count above four reads as four.
//  - digest: eight items per message, word_index 0 (most significant) to 7, with
//    last_word set on index 7.
//  - Timing: a word is taken each cycle while a block fills. The sixteenth word of a
//    block starts the compression: 64 rounds, one round per cycle through the
//    single round unit, then a fold of a..h into the hash; message.ready stays
//    low meanwhile.
//  - End of message: padding words (0x80 mark, zeros, 64-bit length) are pushed one
//    per cycle between compressions, plus an extra block if the length does not fit.
//    Digest words leave one per cycle unless stalled, through an output register.
//  - A stalled receiver holds the current digest word; the hash state waits until
//    all eight are loaded into the output register, then returns to its initial
//    value and the next message is taken while word 7 still waits.
//  - Reset (rst_n, asynchronous, active low) loads the initial hash values, clears
//    the length and the fill count and empties the output register.
`include "assert_macros.svh"

module sha256_message_hasher_core (
    input  logic              clk,
    input  logic              rst_n,
    sha256mh_msg_if.sink      message,
    sha256mh_digest_if.source digest
);
    import sha256mh_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sha256mh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (message.valid),
        .msg_ready    (message.ready),
        .digest_valid (digest.valid),
        .digest_ready (digest.ready),
        .status       (status),
        .cmd          (cmd)
    );

    sha256mh_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .msg    (message.payload),
        .result (digest.payload)
    );

    // No message word may be taken while the round unit is busy
    `ASSERT_IMPLIES(a_no_accept_in_round, clk, rst_n, cmd.round, !message.ready)
    // Schedule window is either filled or stepped, never both
    `ASSERT_IMPLIES(a_push_xor_round, clk, rst_n, cmd.push, !cmd.round)
    // last_word marks exactly index 7
    `ASSERT_IMPLIES(a_last_flag, clk, rst_n, digest.valid,
        digest.payload.last_word == (digest.payload.word_index == LAST_WORD_INDEX))
    // A loaded block always goes straight into its rounds
    `ASSERT_NEXT(a_rounds_follow_load, clk, rst_n, cmd.load_vars, cmd.round)

endmodule

// ===== verif/sha256mh_digest_checker.sv =====
// Digest checker for the SHA-256 hasher: watches both channels, hashes each message itself
// and compares every digest word. Depends on sha256mh_pkg and the stream interface file.
module sha256mh_digest_checker (
    input  logic              clk,
    input  logic              rst_n,
    sha256mh_msg_if           message,
    sha256mh_digest_if        digest,
    output int                mismatches,
    output int unsigned       outstanding,
    output int unsigned       digests_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import sha256mh_pkg::*;

    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    logic [3:0]   fill;
    logic [63:0]  msg_bits;
    digest_item_t expected_digest [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic report_failure(input string what);
        $display("ERROR %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int r;
        for (r = 0; r < 16; r++)
            sched[r] = blk[r];
        for (r = 16; r < 64; r++)
        begin
            s0 = ror(sched[r-15], 7) ^ ror(sched[r-15], 18) ^ (sched[r-15] >> 3);
            s1 = ror(sched[r-2], 17) ^ ror(sched[r-2], 19) ^ (sched[r-2] >> 10);
            sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (r = 0; r < 64; r++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[r] + sched[r];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic absorb(input logic [31:0] w);
        blk[fill] = w;
        if (fill == LAST_SLOT)
            compress_block();
        fill = fill + 4'd1;
    endtask

    // one accepted message word: pad and queue the digest on end of message
    task automatic hash_message_word(input msg_item_t it);
        int unsigned  cnt;
        logic [31:0]  w;
        digest_item_t d;
        cnt = (it.byte_count > FULL_COUNT || !it.end_of_message) ? 4 : it.byte_count;
        w = it.message_word;
        if (cnt == 0)
            w = '0;
        else if (cnt < 4)
            w = w & (32'hFFFF_FFFF << (8 * (4 - cnt)));
        msg_bits += 64'(8 * cnt);
        if (!it.end_of_message)
        begin
            absorb(w);
            return;
        end
        if (cnt == 4)
        begin
            absorb(w);
            absorb(MARK_WORD);
        end
        else
            absorb(w | (32'h80 << (8 * (3 - cnt))));
        // length no longer fits: close this block with zeros
        if (fill > LENGTH_SLOT)
            absorb('0);
        while (fill < LENGTH_SLOT)
            absorb('0);
        absorb(msg_bits[63:32]);
        absorb(msg_bits[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            d.digest_word = chain[k];
            d.word_index  = 3'(k);
            d.last_word   = (3'(k) == LAST_WORD_INDEX);
            expected_digest.push_back(d);
        end
        chain    = HASH_IV;
        msg_bits = '0;
        fill     = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_item_t want;
        digest_item_t got;
        if (!rst_n)
        begin
            chain    = HASH_IV;
            msg_bits = '0;
            fill     = '0;
            expected_digest.delete();
            outstanding <= 0;
        end
        else
        begin
            if (message.valid && message.ready)
                hash_message_word(message.payload);
            if (digest.valid && digest.ready)
            begin
                got = digest.payload;
                digests_seen++;
                if (expected_digest.size() == 0)
                    report_failure($sformatf("unexpected digest word %h index %0d",
                                             got.digest_word, got.word_index));
                else
                begin
                    want = expected_digest.pop_front();
                    if (got.digest_word !== want.digest_word)
                        report_failure($sformatf("digest word %0d: got %h, expected %h",
                                                 want.word_index, got.digest_word,
                                                 want.digest_word));
                    if (got.word_index !== want.word_index)
                        report_failure($sformatf("word index: got %0d, expected %0d",
                                                 got.word_index, want.word_index));
                    if (got.last_word !== want.last_word)
                        report_failure($sformatf("last flag on index %0d: got %b, expected %b",
                                                 want.word_index, got.last_word,
                                                 want.last_word));
                end
            end
            outstanding <= expected_digest.size();
        end
    end

endmodule

// ===== verif/tb_sha256_message_hasher_core.sv =====
// Testbench top for sha256_message_hasher_core: clock, reset, message stimulus and digest
// back-pressure. Depends on sha256mh_pkg, the stream interfaces and sha256mh_digest_checker.
module tb_sha256_message_hasher_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256mh_pkg::*;

    logic clk;
    logic rst_n;

    sha256mh_msg_if    message_ch ();
    sha256mh_digest_if digest_ch ();

    int          mismatches;
    int unsigned outstanding;
    int unsigned digests_seen;

    // words_sent is shared between the sender and the receiver: the long hold-off waits for traffic
    int unsigned words_sent;
    int unsigned messages_sent;
    int unsigned burst_left;

    sha256_message_hasher_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (message_ch),
        .digest  (digest_ch)
    );

    sha256mh_digest_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .message      (message_ch),
        .digest       (digest_ch),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .digests_seen (digests_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // mostly random content, now and then an all-zero or all-one word
    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return 32'h0000_0000;
        if (sel == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Offers one item and returns at the edge it is taken. The sender runs in bursts:
    // when a burst is used up, valid may drop for a random gap before the next one.
    // Each step sees at most one assignment to valid.
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic eom);
        msg_item_t it;
        int unsigned gap;
        it.message_word   = w;
        it.byte_count     = cnt;
        it.end_of_message = eom;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                message_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        message_ch.valid   <= 1'b1;
        message_ch.payload <= it;
        do
            @(posedge clk);
        while (!message_ch.ready);
        words_sent++;
        if (eom)
            messages_sent++;
    endtask

    // Digest receiver: stretches of always-ready, coin-flip, mostly-stalled and fully
    // stalled, each of random length. Once traffic is flowing it holds ready low for
    // a long stretch so the output register and then the message input back up.
    initial
    begin : digest_receiver
        int unsigned mode;
        int unsigned span;
        int unsigned held_cycles;
        bit          hold_done;
        hold_done = 1'b0;
        digest_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && words_sent >= 150)
            begin
                hold_done = 1'b1;
                @(posedge clk);
                digest_ch.ready <= 1'b0;
                held_cycles = 0;
                while (held_cycles < 400)
                begin
                    @(posedge clk);
                    held_cycles++;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       digest_ch.ready <= 1'b1;
                    1:       digest_ch.ready <= 1'($urandom_range(0, 1));
                    2:       digest_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: digest_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    // Message stimulus and verdict
    initial
    begin : message_sender
        int unsigned n_words;
        int unsigned sel;
        int unsigned random_words;
        words_sent    = 0;
        messages_sent = 0;
        burst_left    = 0;
        random_words  = 0;
        rst_n = 1'b0;
        message_ch.valid   <= 1'b0;
        message_ch.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.
        // Empty message: count zero on the closing word, mark lands in the top byte.
        send_word(32'h0000_0000, 3'd0, 1'b1);
        // "abc" with junk in the invalid trailing byte, which must read as zero.
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        // Full final word, all ones.
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        // Count above four on the final word reads as four.
        send_word(32'h1234_5678, 3'd7, 1'b1);
        send_word(32'hA5FF_FFFF, 3'd1, 1'b1);
        send_word(32'h00FF_00FF, 3'd2, 1'b1);
        // Short count on a middle word is ignored: all four bytes count.
        send_word(32'hDEAD_BEEF, 3'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
        // 14 words: the mark fills slot 14, so the length spills into an extra block.
        for (int i = 0; i < 13; i++)
            send_word(32'h0101_0101 * (i + 1), 3'(i % 8), 1'b0);
        send_word(32'hCAFE_F00D, 3'd4, 1'b1);

        // Random messages, weighted towards lengths around the block boundary.
        while (random_words < 480)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 3)
                n_words = $urandom_range(13, 17);
            else if (sel == 3)
                n_words = $urandom_range(18, 40);
            else
                n_words = $urandom_range(1, 12);
            for (int i = 1; i < n_words; i++)
                send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
            send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
            random_words += n_words;
        end
        message_ch.valid <= 1'b0;

        // Drain: every digest word must come back, then let the block settle.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Covered %0d messages in %0d words; %0d digest words checked,", messages_sent,
                 words_sent, digests_seen);
        $display("with boundary-length padding, odd byte counts and a long output stall.");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
